FILE: hdl/cs_pkg.sv
`default_nettype none

package cs_pkg;

    localparam int PIX_W     = 8;
    localparam int DIV_RADIX = 2;
    localparam int NUM_W     = 2 * PIX_W;
    localparam int DIV_STEPS = NUM_W / DIV_RADIX;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 8;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;
    localparam logic [PIX_W-1:0] PIX_MIN = '0;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_REMAP   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HIGH = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic ready;
        logic div_load;
        logic div_step;
        logic emit;
    } t_ctrl;

endpackage

`default_nettype wire

FILE: hdl/cs_div.sv
`default_nettype none

module cs_div (
    input  wire                      i_clk,
    input  wire cs_pkg::t_ctrl       i_ctrl,
    input  wire [cs_pkg::PIX_W-1:0]  i_mag_a,
    input  wire [cs_pkg::PIX_W-1:0]  i_mag_b,
    input  wire [cs_pkg::PIX_W-1:0]  i_den,
    output logic [cs_pkg::NUM_W-1:0] o_quot
);
    import cs_pkg::*;

    logic [NUM_W-1:0] r_dvd;
    logic [NUM_W-1:0] n_dvd;
    logic [PIX_W-1:0] r_rem;
    logic [PIX_W-1:0] n_rem;

    // two restoring steps per cycle, quotient bits shift in at the bottom
    always_comb begin
        logic [PIX_W:0]   t;
        logic [PIX_W-1:0] rem;
        logic [NUM_W-1:0] dvd;
        rem = r_rem;
        dvd = r_dvd;
        for (int k = 0; k < DIV_RADIX; k++) begin
            t   = {rem, dvd[NUM_W-1]};
            dvd = {dvd[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, i_den}) begin
                rem    = PIX_W'(t - {1'b0, i_den});
                dvd[0] = 1'b1;
            end else begin
                rem = t[PIX_W-1:0];
            end
        end
        n_rem = rem;
        n_dvd = dvd;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.div_load) begin
            r_dvd <= NUM_W'(i_mag_a) * NUM_W'(i_mag_b);
            r_rem <= '0;
        end else if (i_ctrl.div_step) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_dvd;

endmodule

`default_nettype wire

FILE: hdl/cs_seq.sv
`default_nettype none

module cs_seq (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start_calc,
    input  wire                 i_start_pass,
    input  wire                 i_out_free,
    output cs_pkg::t_ctrl       o_ctrl
);
    import cs_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_start_calc) begin
                    n_state = S_LOAD;
                end else if (i_start_pass) begin
                    n_state = S_EMIT;
                end
            end
            S_LOAD: begin
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            S_IDLE: o_ctrl.ready    = 1'b1;
            S_LOAD: o_ctrl.div_load = 1'b1;
            S_DIV:  o_ctrl.div_step = 1'b1;
            S_EMIT: o_ctrl.emit     = i_out_free;
            default: o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/contrast_stretch_top.sv
`default_nettype none

// Min-max contrast stretch on 8-bit pixels. A measure transaction (op 0) folds its pixel
// into the running lowest and highest intensity in the cycle it is taken, frame_start
// first discarding the earlier figures; it gives no result and the port is ready again
// in the next cycle. A remap transaction (op 1) returns
// (pixel - lowest) * (target_high - target_low) / (highest - lowest) + target_low,
// signed, quotient truncated toward zero, kept modulo 256. With a flat or unmeasured
// range the pixel comes back unchanged with passed_through set, skipping the load and
// divide states. Otherwise a remap passes through a load of the 8x8 product, then the
// two-bit-per-cycle restoring divider over the 16-bit product, and a write of the output
// register; the input port is not ready meanwhile, and a finished remap waits, with the
// input port still not ready, while that register holds an untaken result. The user must
// write target_low and target_high through the configuration port only while the block
// is idle; the block itself does not enforce this.
module contrast_stretch_top (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire  [7:0] i_s_tdata,   // pixel
    input  wire  [1:0] i_s_tuser,   // op, frame_start
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,   // pixel_out
    output logic       o_m_tuser,   // passed_through
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [7:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data
);
    import cs_pkg::*;

    t_ctrl            ctrl;
    logic             s_acc;
    logic             is_measure;
    logic             is_remap;
    logic             flat;
    logic             out_free;
    logic [PIX_W-1:0] pix;
    logic [PIX_W-1:0] low_base;
    logic [PIX_W-1:0] high_base;
    logic [PIX_W:0]   diff_a;
    logic [PIX_W:0]   diff_b;
    logic [PIX_W:0]   neg_a;
    logic [PIX_W:0]   neg_b;
    logic [NUM_W-1:0] quot;
    logic [NUM_W-1:0] quot_s;
    logic [PIX_W-1:0] result;

    logic [PIX_W-1:0] r_target_low;
    logic [PIX_W-1:0] r_target_high;
    logic [PIX_W-1:0] r_lowest;
    logic [PIX_W-1:0] r_highest;
    logic             r_stats_valid;
    logic [PIX_W-1:0] r_pix;
    logic             r_pass;
    logic             r_neg;
    logic [PIX_W-1:0] r_mag_a;
    logic [PIX_W-1:0] r_mag_b;
    logic [PIX_W-1:0] r_den;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_pass;

    assign pix        = i_s_tdata;
    assign o_s_tready = ctrl.ready;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign is_measure = s_acc && (i_s_tuser[0] == OP_MEASURE);
    assign is_remap   = s_acc && (i_s_tuser[0] == OP_REMAP);
    assign flat       = !r_stats_valid || (r_lowest == r_highest);
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    assign low_base  = i_s_tuser[1] ? PIX_MAX : r_lowest;
    assign high_base = i_s_tuser[1] ? PIX_MIN : r_highest;

    assign diff_a = {1'b0, pix} - {1'b0, r_lowest};
    assign diff_b = {1'b0, r_target_high} - {1'b0, r_target_low};
    assign neg_a  = -diff_a;
    assign neg_b  = -diff_b;

    assign quot_s = r_neg ? -quot : quot;
    assign result = quot_s[PIX_W-1:0] + r_target_low;

    cs_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_calc (is_remap && !flat),
        .i_start_pass (is_remap && flat),
        .i_out_free   (out_free),
        .o_ctrl       (ctrl)
    );

    cs_div u_div (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_mag_a (r_mag_a),
        .i_mag_b (r_mag_b),
        .i_den   (r_den),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_low  <= PIX_MIN;
            r_target_high <= PIX_MAX;
            r_lowest      <= PIX_MAX;
            r_highest     <= PIX_MIN;
            r_stats_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_TARGET_LOW:  r_target_low  <= i_cfg_data;
                    REG_TARGET_HIGH: r_target_high <= i_cfg_data;
                    default: ;
                endcase
            end
            if (is_measure) begin
                r_lowest      <= (pix < low_base) ? pix : low_base;
                r_highest     <= (pix > high_base) ? pix : high_base;
                r_stats_valid <= 1'b1;
            end
            if (ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_remap) begin
            r_pix   <= pix;
            r_pass  <= flat;
            r_neg   <= diff_a[PIX_W] ^ diff_b[PIX_W];
            r_mag_a <= diff_a[PIX_W] ? neg_a[PIX_W-1:0] : diff_a[PIX_W-1:0];
            r_mag_b <= diff_b[PIX_W] ? neg_b[PIX_W-1:0] : diff_b[PIX_W-1:0];
            r_den   <= r_highest - r_lowest;
        end
        if (ctrl.emit) begin
            r_out_pixel <= r_pass ? r_pix : result;
            r_out_pass  <= r_pass;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;
    assign o_m_tuser  = r_out_pass;

`ifndef SYNTHESIS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl.div_load || ctrl.div_step) |-> !o_s_tready)
        else $error("input ready while divider busy");

    a_measure_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_measure |=> r_stats_valid)
        else $error("statistics not valid after measure");

    a_stats_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stats_valid |-> (r_lowest <= r_highest))
        else $error("lowest above highest");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> (!o_m_tvalid || i_m_tready))
        else $error("result written over untaken result");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none

module tb;

    import cs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS = 110;
    localparam int NUM_PHASES = 7;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } t_pix_item;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             passed_through;
    } t_stretch_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic       s_valid = 1'b0;
    logic [7:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic       m_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    wire       o_s_tready;
    wire       o_m_tvalid;
    wire [7:0] o_m_tdata;
    wire       o_m_tuser;
    wire       o_cfg_ready;

    contrast_stretch_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    t_pix_item       pending_items[$];
    t_stretch_result expected_pixels[$];

    // predictor state and its copy of the registers
    logic [PIX_W-1:0] mdl_target_low = PIX_MIN;
    logic [PIX_W-1:0] mdl_target_high = PIX_MAX;
    logic [PIX_W-1:0] mdl_lowest = PIX_MAX;
    logic [PIX_W-1:0] mdl_highest = PIX_MIN;
    logic             mdl_measured = 1'b0;

    logic calm = 1'b0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   stall_cycles = 0;
    int   mismatches = 0;
    int   phase_count = 0;
    t_pix_item cur_item = '0;

    function automatic void stretch_predict(input t_pix_item it);
        int num;
        int den;
        int quot;
        t_stretch_result res;
        if (it.op == OP_MEASURE) begin
            if (it.frame_start) begin
                mdl_lowest = PIX_MAX;
                mdl_highest = PIX_MIN;
                mdl_measured = 1'b0;
            end
            if (it.pixel < mdl_lowest) mdl_lowest = it.pixel;
            if (it.pixel > mdl_highest) mdl_highest = it.pixel;
            mdl_measured = 1'b1;
        end else begin
            if (!mdl_measured || mdl_lowest == mdl_highest) begin
                res.pixel_out = it.pixel;
                res.passed_through = 1'b1;
            end else begin
                num = (int'(it.pixel) - int'(mdl_lowest)) *
                      (int'(mdl_target_high) - int'(mdl_target_low));
                den = int'(mdl_highest) - int'(mdl_lowest);
                quot = num / den;
                res.pixel_out = PIX_W'(quot + int'(mdl_target_low));
                res.passed_through = 1'b0;
            end
            expected_pixels.push_back(res);
        end
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            send_gap = 0;
            mdl_lowest = PIX_MAX;
            mdl_highest = PIX_MIN;
            mdl_measured = 1'b0;
        end else begin
            if (s_valid && o_s_tready) begin
                stretch_predict(cur_item);
                send_gap = calm ? 0 : $urandom_range(0, 9);
            end
            if (!s_valid || o_s_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    cur_item = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_tdata <= cur_item.pixel;
                    s_tuser <= {cur_item.frame_start, cur_item.op};
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_stretch_result want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (o_m_tvalid && m_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t unexpected result: pixel_out %0d passed_through %0d",
                             $time, o_m_tdata, o_m_tuser);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (o_m_tdata !== want.pixel_out) begin
                        $display("%0t pixel_out mismatch: expected %0d actual %0d",
                                 $time, want.pixel_out, o_m_tdata);
                        mismatches++;
                    end
                    if (o_m_tuser !== want.passed_through) begin
                        $display("%0t passed_through mismatch: expected %0d actual %0d",
                                 $time, want.passed_through, o_m_tuser);
                        mismatches++;
                    end
                end
                recv_gap = calm ? 0 : $urandom_range(0, 9);
            end
            if (recv_gap != 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= (hold_left == 0) && !(hold_req && !hold_done);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_tready) || (o_m_tvalid && m_ready) ||
            (cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic add_item(input logic op, input logic [7:0] pixel, input logic fs);
        t_pix_item it;
        it.op = op;
        it.pixel = pixel;
        it.frame_start = fs;
        pending_items.push_back(it);
        phase_count++;
    endtask

    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return PIX_MIN;
            1: return PIX_MAX;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_frame();
        int n_meas;
        int n_remap;
        logic flat;
        logic [7:0] flat_pix;
        logic fresh;
        n_meas = $urandom_range(1, 6);
        n_remap = $urandom_range(1, 8);
        flat = ($urandom_range(0, 5) == 0);
        fresh = ($urandom_range(0, 4) != 0);
        flat_pix = pick_pixel();
        for (int i = 0; i < n_meas; i++) begin
            add_item(OP_MEASURE, flat ? flat_pix : pick_pixel(), (i == 0) && fresh);
        end
        for (int i = 0; i < n_remap; i++) begin
            add_item(OP_REMAP, pick_pixel(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_reg(input logic [7:0] index, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge i_clk);
        while (!(cfg_valid && o_cfg_ready)) @(posedge i_clk);
        cfg_valid <= 1'b0;
        if (index == REG_TARGET_LOW) mdl_target_low = data;
        else if (index == REG_TARGET_HIGH) mdl_target_high = data;
        @(posedge i_clk);
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending_items.size() != 0 || s_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing measured, frame start on remap
        add_item(OP_REMAP, 8'd0, 1'b0);
        add_item(OP_REMAP, 8'd255, 1'b1);
        // flat range
        add_item(OP_MEASURE, 8'd100, 1'b1);
        add_item(OP_REMAP, 8'd100, 1'b0);
        add_item(OP_REMAP, 8'd7, 1'b0);
        // measured range, pixels inside and outside it
        add_item(OP_MEASURE, 8'd50, 1'b0);
        add_item(OP_MEASURE, 8'd200, 1'b0);
        add_item(OP_REMAP, 8'd50, 1'b0);
        add_item(OP_REMAP, 8'd200, 1'b0);
        add_item(OP_REMAP, 8'd125, 1'b0);
        add_item(OP_REMAP, 8'd0, 1'b0);
        add_item(OP_REMAP, 8'd255, 1'b0);
        // full range after restart
        add_item(OP_MEASURE, 8'd0, 1'b1);
        add_item(OP_MEASURE, 8'd255, 1'b0);
        add_item(OP_REMAP, 8'd0, 1'b0);
        add_item(OP_REMAP, 8'd255, 1'b0);
        add_item(OP_REMAP, 8'd128, 1'b1);
        add_item(OP_MEASURE, 8'd128, 1'b1);
        add_item(OP_REMAP, 8'd3, 1'b0);
        add_item(OP_MEASURE, 8'd129, 1'b0);
        add_item(OP_REMAP, 8'd255, 1'b0);
        add_item(OP_REMAP, 8'd0, 1'b0);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin
                    write_reg(REG_TARGET_LOW, 8'd255);
                    write_reg(REG_TARGET_HIGH, 8'd0);
                end
                1: begin
                    write_reg(REG_TARGET_LOW, 8'd0);
                    write_reg(REG_TARGET_HIGH, 8'd0);
                end
                2: begin
                    write_reg(REG_TARGET_LOW, 8'd255);
                    write_reg(REG_TARGET_HIGH, 8'd255);
                end
                3: begin
                    write_reg(REG_TARGET_LOW, 8'd0);
                    write_reg(REG_TARGET_HIGH, 8'd255);
                    // out of range index is dropped
                    write_reg(8'($urandom_range(2, 255)), 8'($urandom_range(0, 255)));
                    write_reg(8'd255, 8'd77);
                end
                default: begin
                    write_reg(REG_TARGET_LOW, 8'($urandom_range(0, 255)));
                    write_reg(REG_TARGET_HIGH, 8'($urandom_range(0, 255)));
                end
            endcase
            calm <= (p == 2) || (p == 4);
            if (p == 4) hold_req <= 1'b1;
            phase_count = 0;
            if (p == 0) begin
                add_item(OP_MEASURE, 8'd10, 1'b1);
                add_item(OP_MEASURE, 8'd20, 1'b0);
                add_item(OP_REMAP, 8'd15, 1'b0);
                add_item(OP_REMAP, 8'd0, 1'b0);
                add_item(OP_REMAP, 8'd255, 1'b0);
            end
            while (phase_count < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0)
                    add_item(1'($urandom_range(0, 1)), pick_pixel(), 1'($urandom_range(0, 1)));
                else
                    add_frame();
            end
            drain();
        end

        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
